// File: src/jtl_pkg.sv
// ----------------------------------------------------------------------------
// jtl_pkg: shared types and tables for the jack token lexer
// payload structs, record codes, token classes and the keyword table
// ----------------------------------------------------------------------------
`default_nettype none

package jtl_pkg;

  localparam int unsigned NumKeywords = 21;
  localparam int unsigned MaxRecords  = 4;

  // record kinds
  localparam logic [1:0] KindChar  = 2'd0;
  localparam logic [1:0] KindEnd   = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  // token classes
  localparam logic [2:0] ClsKeyword = 3'd0;
  localparam logic [2:0] ClsSymbol  = 3'd1;
  localparam logic [2:0] ClsInteger = 3'd2;
  localparam logic [2:0] ClsString  = 3'd3;
  localparam logic [2:0] ClsIdent   = 3'd4;

  // special characters
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNewline = 8'h0A;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [1:0] record_kind;
    logic [7:0] token_byte;
    logic [2:0] token_class;
    logic [4:0] keyword_number;
    logic       last_of_run;
  } out_t;

  // keyword text, right aligned, first character in the highest used byte
  function automatic logic [95:0] kw_text(input logic [4:0] k);
    logic [95:0] t;
    unique case (k)
      5'd0:    t = "class";
      5'd1:    t = "constructor";
      5'd2:    t = "function";
      5'd3:    t = "method";
      5'd4:    t = "field";
      5'd5:    t = "static";
      5'd6:    t = "var";
      5'd7:    t = "int";
      5'd8:    t = "char";
      5'd9:    t = "boolean";
      5'd10:   t = "void";
      5'd11:   t = "true";
      5'd12:   t = "false";
      5'd13:   t = "null";
      5'd14:   t = "this";
      5'd15:   t = "let";
      5'd16:   t = "do";
      5'd17:   t = "if";
      5'd18:   t = "else";
      5'd19:   t = "while";
      5'd20:   t = "return";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    logic [3:0] l;
    unique case (k)
      5'd0:    l = 4'd5;
      5'd1:    l = 4'd11;
      5'd2:    l = 4'd8;
      5'd3:    l = 4'd6;
      5'd4:    l = 4'd5;
      5'd5:    l = 4'd6;
      5'd6:    l = 4'd3;
      5'd7:    l = 4'd3;
      5'd8:    l = 4'd4;
      5'd9:    l = 4'd7;
      5'd10:   l = 4'd4;
      5'd11:   l = 4'd4;
      5'd12:   l = 4'd5;
      5'd13:   l = 4'd4;
      5'd14:   l = 4'd4;
      5'd15:   l = 4'd3;
      5'd16:   l = 4'd2;
      5'd17:   l = 4'd2;
      5'd18:   l = 4'd4;
      5'd19:   l = 4'd5;
      5'd20:   l = 4'd6;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  // character i of keyword k, zero past its end
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] i);
    logic [95:0] t;
    logic [3:0]  l;
    logic [3:0]  d;
    logic [6:0]  base;
    t = kw_text(k);
    l = kw_len(k);
    d = 4'(l - 4'd1 - i);
    base = {d, 3'b000};
    if (i >= l) begin
      return 8'd0;
    end
    return t[base +: 8];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    logic r;
    unique case (c)
      "{", "}", "(", ")", "[", "]", ".", ",", ";", "+", "-", "*",
      "/", "&", "|", "<", ">", "=", "~": r = 1'b1;
      default:                          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/jack_token_lexer.sv
// ----------------------------------------------------------------------------
// jack_token_lexer: streaming tokenizer for jack source text
// strips comments, echoes token bytes and tags each token end with its class
// ----------------------------------------------------------------------------
// One source byte enters per input transaction. The lexer state and the byte
// are decoded in a single pass of shallow logic (21 keyword compares in
// parallel against a candidate mask) and the up to four result records of
// that byte are loaded into a four-entry result buffer. The buffer drains one
// record per output transaction, so a byte holds the output side until all
// of its records have left, and a new byte is taken in the cycle the last
// record of the previous one leaves. A byte that yields no record (white
// space, comment text, a held-back slash) leaves the buffer empty. Sustained
// rate is one byte per cycle when the output is always ready and each byte
// yields at most one record; the result buffer drain sets the rate otherwise.
`default_nettype none

module jack_token_lexer
  import jtl_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  wire in_t in_data_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output out_t out_data_o
);

  typedef enum logic [2:0] {
    ModeNormal    = 3'd0,
    ModeSlash     = 3'd1,
    ModeLine      = 3'd2,
    ModeBlock     = 3'd3,
    ModeBlockStar = 3'd4,
    ModeString    = 3'd5
  } mode_e;

  // lexer state
  mode_e             mode_q, mode_d;
  logic              open_q, open_d;
  logic [3:0]        len_q, len_d;
  logic [NumKeywords-1:0] cand_q, cand_d;
  logic              dig_q, dig_d;

  // result buffer, head at entry 0
  out_t              buf_q [MaxRecords];
  out_t              recs  [MaxRecords];
  logic [2:0]        cnt_q;
  logic [2:0]        n;

  logic              in_acc;
  logic              out_pop;

  // word bookkeeping seen through a closed word
  logic [3:0]        eff_len;
  logic [NumKeywords-1:0] eff_cand;
  logic [NumKeywords-1:0] cand_next;
  logic              dig_next;
  logic [3:0]        len_next;
  logic              kw_hit;
  logic [4:0]        kw_idx;
  logic              do_normal;
  logic [7:0]        c;

  assign c = in_data_i.source_byte;

  // handshakes: take a byte once the buffer is empty or its last record leaves
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = buf_q[0];
  assign out_pop     = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;

  // candidate narrowing for the next word character
  always_comb begin
    eff_len  = open_q ? len_q : 4'd0;
    eff_cand = open_q ? cand_q : '1;
    for (int k = 0; k < NumKeywords; k++) begin
      cand_next[k] = eff_cand[k] && (eff_len < kw_len(5'(k))) &&
                     (kw_char(5'(k), eff_len) == c);
    end
    dig_next = (open_q ? dig_q : 1'b1) && (c >= "0") && (c <= "9");
    len_next = (eff_len == 4'd15) ? eff_len : 4'(eff_len + 4'd1);
  end

  // keyword lookup on the open word, lowest index wins
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 5'd0;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      if (cand_q[k] && (kw_len(5'(k)) == len_q)) begin
        kw_hit = 1'b1;
        kw_idx = 5'(k);
      end
    end
  end

  // single pass step: next state and the records of this byte
  always_comb begin
    mode_d    = mode_q;
    open_d    = open_q;
    len_d     = len_q;
    cand_d    = cand_q;
    dig_d     = dig_q;
    n         = 3'd0;
    do_normal = 1'b0;
    for (int r = 0; r < MaxRecords; r++) begin
      recs[r] = '0;
    end

    if (in_data_i.end_of_input) begin
      // flush pending slash, string or word
      if (mode_q == ModeSlash) begin
        recs[n[1:0]] = '{KindChar, ChSlash, 3'd0, 5'd0, 1'b0};
        n = 3'(n + 3'd1);
        recs[n[1:0]] = '{KindEnd, 8'd0, ClsSymbol, 5'd0, 1'b0};
        n = 3'(n + 3'd1);
      end else if (mode_q == ModeString) begin
        recs[n[1:0]] = '{KindError, 8'd0, ClsString, 5'd0, 1'b0};
        n = 3'(n + 3'd1);
      end
      if (open_q) begin
        recs[n[1:0]] = kw_hit ? out_t'{KindEnd, 8'd0, ClsKeyword, kw_idx, 1'b0}
                              : out_t'{KindEnd, 8'd0, dig_q ? ClsInteger : ClsIdent,
                                       5'd0, 1'b0};
        n = 3'(n + 3'd1);
        open_d = 1'b0;
        len_d  = 4'd0;
        cand_d = '1;
        dig_d  = 1'b1;
      end
      mode_d = ModeNormal;
    end else begin
      unique case (mode_q)
        ModeSlash: begin
          if (c == ChSlash) begin
            mode_d = ModeLine;
          end else if (c == ChStar) begin
            mode_d = ModeBlock;
          end else begin
            // lone slash is the division symbol
            mode_d = ModeNormal;
            recs[n[1:0]] = '{KindChar, ChSlash, 3'd0, 5'd0, 1'b0};
            n = 3'(n + 3'd1);
            recs[n[1:0]] = '{KindEnd, 8'd0, ClsSymbol, 5'd0, 1'b0};
            n = 3'(n + 3'd1);
            do_normal = 1'b1;
          end
        end
        ModeLine: begin
          if (c == ChNewline) begin
            mode_d = ModeNormal;
          end
        end
        ModeBlock: begin
          if (c == ChStar) begin
            mode_d = ModeBlockStar;
          end
        end
        ModeBlockStar: begin
          if (c == ChSlash) begin
            mode_d = ModeNormal;
          end else if (c != ChStar) begin
            mode_d = ModeBlock;
          end
        end
        ModeString: begin
          if (c == ChQuote) begin
            recs[n[1:0]] = '{KindEnd, 8'd0, ClsString, 5'd0, 1'b0};
            n = 3'(n + 3'd1);
            mode_d = ModeNormal;
          end else if (c == ChNewline) begin
            recs[n[1:0]] = '{KindError, 8'd0, ClsString, 5'd0, 1'b0};
            n = 3'(n + 3'd1);
            mode_d = ModeNormal;
          end else begin
            recs[n[1:0]] = '{KindChar, c, 3'd0, 5'd0, 1'b0};
            n = 3'(n + 3'd1);
          end
        end
        default: begin
          mode_d    = ModeNormal;
          do_normal = 1'b1;
        end
      endcase

      if (do_normal) begin
        if (is_space(c) || (c == ChSlash) || is_symbol(c) || (c == ChQuote)) begin
          // word enders close any open word first
          if (open_q) begin
            recs[n[1:0]] = kw_hit ? out_t'{KindEnd, 8'd0, ClsKeyword, kw_idx, 1'b0}
                                  : out_t'{KindEnd, 8'd0, dig_q ? ClsInteger : ClsIdent,
                                           5'd0, 1'b0};
            n = 3'(n + 3'd1);
            open_d = 1'b0;
            len_d  = 4'd0;
            cand_d = '1;
            dig_d  = 1'b1;
          end
          priority if (is_space(c)) begin
            mode_d = ModeNormal;
          end else if (c == ChSlash) begin
            mode_d = ModeSlash;
          end else if (is_symbol(c)) begin
            recs[n[1:0]] = '{KindChar, c, 3'd0, 5'd0, 1'b0};
            n = 3'(n + 3'd1);
            recs[n[1:0]] = '{KindEnd, 8'd0, ClsSymbol, 5'd0, 1'b0};
            n = 3'(n + 3'd1);
          end else begin
            mode_d = ModeString;
          end
        end else begin
          // word character
          open_d = 1'b1;
          len_d  = len_next;
          cand_d = cand_next;
          dig_d  = dig_next;
          recs[n[1:0]] = '{KindChar, c, 3'd0, 5'd0, 1'b0};
          n = 3'(n + 3'd1);
        end
      end
    end

    // mark the final record of this byte
    if (n != 3'd0) begin
      recs[2'(n - 3'd1)].last_of_run = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      open_q <= 1'b0;
      len_q  <= 4'd0;
      cand_q <= '1;
      dig_q  <= 1'b1;
      cnt_q  <= 3'd0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      open_q <= open_d;
      len_q  <= len_d;
      cand_q <= cand_d;
      dig_q  <= dig_d;
      cnt_q  <= n;
    end else if (out_pop) begin
      cnt_q <= 3'(cnt_q - 3'd1);
    end
  end

  // result buffer payload, shifts toward the head on each output transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int r = 0; r < MaxRecords; r++) begin
        buf_q[r] <= recs[r];
      end
    end else if (out_pop) begin
      for (int r = 0; r < MaxRecords - 1; r++) begin
        buf_q[r] <= buf_q[r+1];
      end
    end
  end

  // buffer never holds more than one byte's worth of records
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(MaxRecords))
    else $error("result buffer count out of range");

  // a byte is only taken when the buffer is empty or empties in the same cycle
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_pop)))
    else $error("byte accepted over pending records");

  // last_of_run flags exactly the final buffered record
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_of_run == (cnt_q == 3'd1)))
    else $error("last_of_run out of step with buffer count");

  // token bytes never carry a class, end and error records never carry a byte
  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.record_kind == KindChar) ?
                     (out_data_o.token_class == 3'd0) :
                     (out_data_o.token_byte == 8'd0)))
    else $error("record fields inconsistent with kind");

endmodule

`default_nettype wire

// File: bench/tb_jack_token_lexer.sv
// ----------------------------------------------------------------------------
// tb_jack_token_lexer: self-checking bench for the jack token lexer
// a directed table and random source text go through a bit-exact lexer
// predictor, and every output record is checked field by field in order
// ----------------------------------------------------------------------------

module tb_jack_token_lexer
  import jtl_pkg::*;
();

  // lexer modes of the predictor
  typedef enum logic [2:0] {
    LmNormal, LmSlash, LmLine, LmBlock, LmBlockStar, LmString
  } lex_mode_e;

  // one stimulus row: source byte, end flag and up to three records typed in
  // by hand; n_typed of zero means the predictor supplies the records
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic [1:0] n_typed;
    out_t       r0;
    out_t       r1;
    out_t       r2;
  } stim_row_t;

  localparam logic [2:0] ClsNone = 3'd0;
  localparam out_t       NoRec   = '0;

  // sender quiet window in items, receiver windows in cycles
  localparam int unsigned TxQuietLo = 90;
  localparam int unsigned TxQuietHi = 140;
  localparam int unsigned RxHoldLo  = 150;
  localparam int unsigned RxHoldHi  = 230;
  localparam int unsigned RxQuietLo = 350;
  localparam int unsigned RxQuietHi = 550;

  localparam string KwNames [21] = '{
    "class", "constructor", "function", "method", "field", "static",
    "var", "int", "char", "boolean", "void", "true", "false", "null",
    "this", "let", "do", "if", "else", "while", "return"
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  stim_row_t cur_row = '0;
  in_t       in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_t      out_data;

  assign in_data = {cur_row.ch, cur_row.eoi};

  jack_token_lexer u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // lexer predictor
  // --------------------------------------------------------------------------
  lex_mode_e   lx_mode = LmNormal;
  logic        lx_word_open = 1'b0;
  logic [3:0]  lx_word_len = '0;
  logic [20:0] lx_kw_cand = '1;
  logic        lx_digits_only = 1'b1;

  // records produced by the byte just lexed
  out_t        lx_recs [4];
  int          lx_rec_count;

  out_t        token_records_due [$];
  int unsigned fault_count = 0;
  int unsigned items_sent = 0;
  stim_row_t   stim_q [$];

  function automatic out_t rec(logic [1:0] kind, logic [7:0] b, logic [2:0] cls,
                               logic [4:0] kw, logic last);
    return {kind, b, cls, kw, last};
  endfunction

  function automatic stim_row_t row(logic [7:0] ch, logic eoi, logic [1:0] n,
                                    out_t a, out_t b, out_t c);
    return {ch, eoi, n, a, b, c};
  endfunction

  function automatic void emit(logic [1:0] kind, logic [7:0] b, logic [2:0] cls,
                               logic [4:0] kw);
    lx_recs[lx_rec_count] = rec(kind, b, cls, kw, 1'b0);
    lx_rec_count++;
  endfunction

  function automatic logic blank_char(logic [7:0] c);
    return (c == " ") || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic punct_char(logic [7:0] c);
    case (c)
      "{", "}", "(", ")", "[", "]", ".", ",", ";", "+", "-", "*",
      "/", "&", "|", "<", ">", "=", "~": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // close an open word: first surviving keyword of the right length wins,
  // else integer when all digits, else identifier
  function automatic void close_word();
    logic hit;
    hit = 1'b0;
    if (!lx_word_open) return;
    lx_word_open = 1'b0;
    for (int k = 0; k < 21; k++) begin
      if (!hit && lx_kw_cand[k] && KwNames[k].len() == int'(lx_word_len)) begin
        emit(KindEnd, 8'h00, ClsKeyword, 5'(k));
        hit = 1'b1;
      end
    end
    if (!hit) emit(KindEnd, 8'h00, lx_digits_only ? ClsInteger : ClsIdent, 5'd0);
    lx_word_len = '0;
    lx_kw_cand = '1;
    lx_digits_only = 1'b1;
  endfunction

  // narrow the keyword mask by one character, length saturates at 15
  function automatic void grow_word(logic [7:0] c);
    logic [7:0] kc;
    if (!lx_word_open) begin
      lx_word_open = 1'b1;
      lx_word_len = '0;
      lx_kw_cand = '1;
      lx_digits_only = 1'b1;
    end
    for (int k = 0; k < 21; k++) begin
      kc = (int'(lx_word_len) < KwNames[k].len()) ? KwNames[k][lx_word_len] : 8'h00;
      if (int'(lx_word_len) >= KwNames[k].len() || kc != c) lx_kw_cand[k] = 1'b0;
    end
    if (c < "0" || c > "9") lx_digits_only = 1'b0;
    if (lx_word_len != 4'd15) lx_word_len++;
  endfunction

  function automatic void plain_text_byte(logic [7:0] c);
    if (blank_char(c)) begin
      close_word();
    end else if (c == ChSlash) begin
      close_word();
      lx_mode = LmSlash;
    end else if (punct_char(c)) begin
      close_word();
      emit(KindChar, c, ClsNone, 5'd0);
      emit(KindEnd, 8'h00, ClsSymbol, 5'd0);
    end else if (c == ChQuote) begin
      close_word();
      lx_mode = LmString;
    end else begin
      grow_word(c);
      emit(KindChar, c, ClsNone, 5'd0);
    end
  endfunction

  function automatic void lex_source_byte(logic [7:0] c, logic eoi);
    lx_rec_count = 0;
    if (eoi) begin
      // flush: held slash becomes a symbol, open string is an error
      if (lx_mode == LmSlash) begin
        emit(KindChar, ChSlash, ClsNone, 5'd0);
        emit(KindEnd, 8'h00, ClsSymbol, 5'd0);
      end else if (lx_mode == LmString) begin
        emit(KindError, 8'h00, ClsString, 5'd0);
      end
      close_word();
      lx_mode = LmNormal;
    end else begin
      case (lx_mode)
        LmSlash: begin
          if (c == ChSlash) begin
            lx_mode = LmLine;
          end else if (c == ChStar) begin
            lx_mode = LmBlock;
          end else begin
            lx_mode = LmNormal;
            emit(KindChar, ChSlash, ClsNone, 5'd0);
            emit(KindEnd, 8'h00, ClsSymbol, 5'd0);
            plain_text_byte(c);
          end
        end
        LmLine: begin
          if (c == ChNewline) lx_mode = LmNormal;
        end
        LmBlock: begin
          if (c == ChStar) lx_mode = LmBlockStar;
        end
        LmBlockStar: begin
          if (c == ChSlash) lx_mode = LmNormal;
          else if (c != ChStar) lx_mode = LmBlock;
        end
        LmString: begin
          if (c == ChQuote) begin
            emit(KindEnd, 8'h00, ClsString, 5'd0);
            lx_mode = LmNormal;
          end else if (c == ChNewline) begin
            emit(KindError, 8'h00, ClsString, 5'd0);
            lx_mode = LmNormal;
          end else begin
            emit(KindChar, c, ClsNone, 5'd0);
          end
        end
        default: begin
          lx_mode = LmNormal;
          plain_text_byte(c);
        end
      endcase
    end
    if (lx_rec_count > 0) lx_recs[lx_rec_count - 1].last_of_run = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // random source text
  // --------------------------------------------------------------------------
  function automatic void put_item(logic [7:0] c, logic eoi);
    stim_q.push_back(row(c, eoi, 2'd0, NoRec, NoRec, NoRec));
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put_item(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] rand_letter();
    int unsigned p;
    p = $urandom_range(52);
    if (p < 26) return 8'("a" + p);
    if (p < 52) return 8'("A" + p - 26);
    return "_";
  endfunction

  function automatic void put_ident(int unsigned len);
    put_item(rand_letter(), 1'b0);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(3) == 0) put_item(8'("0" + $urandom_range(9)), 1'b0);
      else put_item(rand_letter(), 1'b0);
    end
  endfunction

  // one fragment of plausible jack text, with some noise and broken pieces
  function automatic void put_fragment();
    string       puncts;
    string       blanks;
    string       inner;
    string       kw;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  c;
    puncts = "{}()[].,;+-*&|<>=~/";
    blanks = " \t\n\r\v\f";
    inner  = "a*/ \nq*";
    pick = $urandom_range(99);
    if (pick < 20) begin
      put_str(KwNames[$urandom_range(20)]);
    end else if (pick < 32) begin
      // mostly short names, now and then one past the length counter
      put_ident(($urandom_range(7) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 8));
    end else if (pick < 42) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) put_item(8'("0" + $urandom_range(9)), 1'b0);
    end else if (pick < 56) begin
      put_item(puncts[$urandom_range(puncts.len() - 1)], 1'b0);
    end else if (pick < 66) begin
      put_item(ChQuote, 1'b0);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(32, 255));
        put_item((c == ChQuote) ? 8'h27 : c, 1'b0);
      end
      put_item(ChQuote, 1'b0);
    end else if (pick < 72) begin
      put_str("//");
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(255));
        put_item((c == ChNewline) ? 8'h20 : c, 1'b0);
      end
      put_item(ChNewline, 1'b0);
    end else if (pick < 78) begin
      put_str("/*");
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) put_item(inner[$urandom_range(inner.len() - 1)], 1'b0);
      put_str("*/");
    end else if (pick < 84) begin
      // keyword with a tail, or a cut-off keyword
      kw = KwNames[$urandom_range(20)];
      if ($urandom_range(1)) begin
        put_str(kw);
        put_item(rand_letter(), 1'b0);
      end else begin
        put_str(kw.substr(0, $urandom_range(kw.len() - 2)));
      end
    end else if (pick < 89) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) put_item(8'($urandom_range(255)), 1'b0);
    end else if (pick < 92) begin
      put_item(ChQuote, 1'b0);
      put_ident($urandom_range(1, 4));
      put_item(ChNewline, 1'b0);
    end else if (pick < 96) begin
      // end of input, mostly with something left open
      case ($urandom_range(5))
        0: put_str("/");
        1: put_str("/*a");
        2: put_str("//x");
        3: put_str("\"ab");
        4: put_ident($urandom_range(1, 4));
        default: ;
      endcase
      put_item(8'($urandom_range(255)), 1'b1);
    end else begin
      put_item(blanks[$urandom_range(blanks.len() - 1)], 1'b0);
    end
    if ($urandom_range(9) < 6) put_item(blanks[$urandom_range(blanks.len() - 1)], 1'b0);
  endfunction

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  function automatic void load_directed();
    // byte extremes are word characters, a blank closes them as a name
    stim_q.push_back(row(8'h00, 1'b0, 2'd1, rec(KindChar, 8'h00, ClsNone, 5'd0, 1'b1),
                         NoRec, NoRec));
    stim_q.push_back(row(8'hFF, 1'b0, 2'd1, rec(KindChar, 8'hFF, ClsNone, 5'd0, 1'b1),
                         NoRec, NoRec));
    stim_q.push_back(row(" ", 1'b0, 2'd1, rec(KindEnd, 8'h00, ClsIdent, 5'd0, 1'b1),
                         NoRec, NoRec));
    // "if(" ends a keyword on a symbol
    stim_q.push_back(row("i", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row("f", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row("(", 1'b0, 2'd3, rec(KindEnd, 8'h00, ClsKeyword, 5'd17, 1'b0),
                         rec(KindChar, "(", ClsNone, 5'd0, 1'b0),
                         rec(KindEnd, 8'h00, ClsSymbol, 5'd0, 1'b1)));
    // line comment
    stim_q.push_back(row("/", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row("/", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row(ChNewline, 1'b0, 2'd0, NoRec, NoRec, NoRec));
    // "/*/*/": opening star does not close the comment
    stim_q.push_back(row("/", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row("*", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row("/", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row("*", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row("/", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    // closed string, then newline inside a string
    stim_q.push_back(row(ChQuote, 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row("a", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row(ChQuote, 1'b0, 2'd1, rec(KindEnd, 8'h00, ClsString, 5'd0, 1'b1),
                         NoRec, NoRec));
    stim_q.push_back(row(ChQuote, 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row(ChNewline, 1'b0, 2'd1,
                         rec(KindError, 8'h00, ClsString, 5'd0, 1'b1), NoRec, NoRec));
    // integer closed by a slash, then division followed by a symbol
    stim_q.push_back(row("7", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row("/", 1'b0, 2'd1, rec(KindEnd, 8'h00, ClsInteger, 5'd0, 1'b1),
                         NoRec, NoRec));
    stim_q.push_back(row("+", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    // end of input flushes a held slash, then ends an open string
    stim_q.push_back(row("/", 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row("q", 1'b1, 2'd2, rec(KindChar, ChSlash, ClsNone, 5'd0, 1'b0),
                         rec(KindEnd, 8'h00, ClsSymbol, 5'd0, 1'b1), NoRec));
    stim_q.push_back(row(ChQuote, 1'b0, 2'd0, NoRec, NoRec, NoRec));
    stim_q.push_back(row(8'hFF, 1'b1, 2'd1, rec(KindError, 8'h00, ClsString, 5'd0, 1'b1),
                         NoRec, NoRec));
  endfunction

  // --------------------------------------------------------------------------
  // monitor: predict on each input transaction, check each output transaction
  // --------------------------------------------------------------------------
  task automatic field_mismatch(string field, logic [7:0] want, logic [7:0] got);
    $display("%0t: %s mismatch, expected 0x%h, got 0x%h", $time, field, want, got);
    fault_count++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        // predictor always runs so its state tracks the hand-typed rows
        lex_source_byte(cur_row.ch, cur_row.eoi);
        if (cur_row.n_typed != 2'd0) begin
          token_records_due.push_back(cur_row.r0);
          if (cur_row.n_typed > 2'd1) token_records_due.push_back(cur_row.r1);
          if (cur_row.n_typed > 2'd2) token_records_due.push_back(cur_row.r2);
        end else begin
          for (int i = 0; i < lx_rec_count; i++) token_records_due.push_back(lx_recs[i]);
        end
      end
      if (out_valid && out_ready) begin
        if (token_records_due.size() == 0) begin
          $display("%0t: unexpected record, expected none, got %h", $time, out_data);
          fault_count++;
        end else begin
          want = token_records_due.pop_front();
          if (out_data.record_kind !== want.record_kind)
            field_mismatch("record_kind", 8'(want.record_kind), 8'(out_data.record_kind));
          if (out_data.token_byte !== want.token_byte)
            field_mismatch("token_byte", want.token_byte, out_data.token_byte);
          if (out_data.token_class !== want.token_class)
            field_mismatch("token_class", 8'(want.token_class), 8'(out_data.token_class));
          if (out_data.keyword_number !== want.keyword_number)
            field_mismatch("keyword_number", 8'(want.keyword_number),
                           8'(out_data.keyword_number));
          if (out_data.last_of_run !== want.last_of_run)
            field_mismatch("last_of_run", 8'(want.last_of_run), 8'(out_data.last_of_run));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off so the result buffer fills
  // and the input stalls, then a stretch that is always ready
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_cycle >= RxHoldLo && rx_cycle < RxHoldHi) out_ready <= 1'b0;
      else if (rx_cycle >= RxQuietLo && rx_cycle < RxQuietHi) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 30);
      rx_cycle++;
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // sender: one transaction per row, valid held until accepted
  // --------------------------------------------------------------------------
  task automatic offer(stim_row_t r);
    while (!(items_sent >= TxQuietLo && items_sent < TxQuietHi) &&
           $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cur_row  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    load_directed();
    while (stim_q.size() < 168) put_fragment();
    put_item(8'h00, 1'b1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_q[i]) offer(stim_q[i]);
    in_valid <= 1'b0;
    @(posedge clk);

    // drain, then keep watching to catch stray records
    while (token_records_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fault_count == 0) begin
      $display("[jack_token_lexer] OK");
    end else begin
      $display("[jack_token_lexer] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800000;
    $display("[jack_token_lexer] ERROR");
    $finish;
  end

endmodule
